@@ hw/rtl/psfp_pkg.sv @@
// Shared types and constants for the particle sensor frame parser.
// No dependencies; every other file takes names from here by scope.
`default_nettype none
package psfp_pkg;

  // Frame geometry
  localparam int FRAME_BYTES = 32;
  localparam int BODY_BYTES  = FRAME_BYTES - 2;
  localparam int CK_POS      = BODY_BYTES - 2;
  localparam int NUM_WORDS   = 12;
  localparam int CNT_W       = $clog2(BODY_BYTES + 1);
  localparam int ADDR_W      = $clog2(BODY_BYTES);
  localparam int POS_MAX     = (BODY_BYTES > 2 * NUM_WORDS + 2) ? BODY_BYTES
                                                                : 2 * NUM_WORDS + 2;
  localparam int POS_W       = $clog2(POS_MAX + 1);

  // Field widths
  localparam int OP_W     = 2;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int IDX_W    = 4;
  localparam int VALUE_W  = 16;
  localparam int TICK_W   = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_HDR_TIMEOUT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BODY_TIMEOUT = 1'd1;

  localparam logic [TICK_W-1:0] HDR_TIMEOUT_RST  = 16'd1000;
  localparam logic [TICK_W-1:0] BODY_TIMEOUT_RST = 16'd200;

  localparam logic [BYTE_W-1:0]  HDR_A        = 8'h42;
  localparam logic [BYTE_W-1:0]  HDR_B        = 8'h4D;
  localparam logic [VALUE_W-1:0] HDR_SUM      = 16'h008F;
  localparam logic [VALUE_W-1:0] LEN_EXPECTED = 16'd28;

  localparam int JOB_FIFO_DEPTH = 2;

  typedef enum logic [OP_W-1:0] {
    OP_BYTE  = 2'd0,
    OP_TICK  = 2'd1,
    OP_START = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_LEN     = 2'd1,
    ST_CKSUM   = 2'd2,
    ST_HDR_TO  = 2'd3
  } status_e;

  // One queued job for the back end: a full frame to unpack, or a status.
  typedef struct packed {
    logic    is_frame;
    status_e status;
  } job_t;

  // Frame store write from the front end.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } store_wr_t;

  // Back end report to the front end.
  typedef struct packed {
    logic frame_done;
  } back_stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/psfp_if.sv @@
// Valid/ready channel interfaces: input items, result items, config writes.
// Depends on psfp_pkg for field widths.
`default_nettype none
interface psfp_in_if;
  logic                        valid;
  logic                        ready;
  logic [psfp_pkg::OP_W-1:0]   op;
  logic [psfp_pkg::BYTE_W-1:0] byte_value;
  modport source (output valid, output op, output byte_value, input ready);
  modport sink   (input valid, input op, input byte_value, output ready);
endinterface

interface psfp_out_if;
  logic                          valid;
  logic                          ready;
  logic [psfp_pkg::STATUS_W-1:0] status;
  logic [psfp_pkg::IDX_W-1:0]    field_index;
  logic [psfp_pkg::VALUE_W-1:0]  value;
  logic                          last;
  modport source (output valid, output status, output field_index, output value,
                  output last, input ready);
  modport sink   (input valid, input status, input field_index, input value,
                  input last, output ready);
endinterface

interface psfp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [psfp_pkg::CFG_IDX_W-1:0]  index;
  logic [psfp_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/psfp_front.sv @@
// Front end: accepts items and config writes, hunts the header, collects the body,
// checks length and checksum, queues jobs. Uses psfp_pkg and psfp_if.
`default_nettype none
module psfp_front (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  psfp_in_if.sink                  in_i,
  psfp_cfg_if.sink                 cfg_i,
  input  wire                      q_full_i,
  output logic                     q_push_o,
  output psfp_pkg::job_t           q_job_o,
  output psfp_pkg::store_wr_t      store_wr_o,
  input  psfp_pkg::back_stat_t     back_stat_i
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HUNT = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  localparam logic [psfp_pkg::CNT_W-1:0] CNT_LAST =
    psfp_pkg::CNT_W'(psfp_pkg::BODY_BYTES - 1);
  localparam logic [psfp_pkg::CNT_W-1:0] CNT_CK_HI =
    psfp_pkg::CNT_W'(psfp_pkg::CK_POS);
  localparam logic [psfp_pkg::TICK_W-1:0] TICK_MAX = '1;

  logic [1:0]                      phase_q, phase_d;
  logic                            saw_q, saw_d;
  logic [psfp_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic [psfp_pkg::VALUE_W-1:0]    sum_q, sum_d;
  logic [psfp_pkg::TICK_W-1:0]     tick_q, tick_d;
  logic [psfp_pkg::VALUE_W-1:0]    len_q, len_d;
  logic [psfp_pkg::BYTE_W-1:0]     ck_hi_q, ck_hi_d;
  logic                            pend_q, pend_d;
  logic [psfp_pkg::TICK_W-1:0]     hdr_to_q, body_to_q;

  logic                            acc;
  logic [psfp_pkg::TICK_W-1:0]     tick_inc;
  psfp_pkg::op_e                   op;

  assign op          = psfp_pkg::op_e'(in_i.op);
  assign in_i.ready  = !q_full_i && !pend_q;
  assign acc         = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign tick_inc    = (tick_q == TICK_MAX) ? tick_q : tick_q + 1'b1;

  always_comb begin
    phase_d    = phase_q;
    saw_d      = saw_q;
    cnt_d      = cnt_q;
    sum_d      = sum_q;
    tick_d     = tick_q;
    len_d      = len_q;
    ck_hi_d    = ck_hi_q;
    pend_d     = pend_q;
    q_push_o   = 1'b0;
    q_job_o    = '{is_frame: 1'b0, status: psfp_pkg::ST_OK};
    store_wr_o = '{en: 1'b0, addr: cnt_q[psfp_pkg::ADDR_W-1:0], data: in_i.byte_value};
    if (back_stat_i.frame_done) begin
      pend_d = 1'b0;
    end
    if (acc) begin
      case (op)
        psfp_pkg::OP_START: begin
          phase_d = PH_HUNT;
          saw_d   = 1'b0;
          cnt_d   = '0;
          sum_d   = '0;
          tick_d  = '0;
        end
        psfp_pkg::OP_TICK: begin
          if (phase_q != PH_IDLE) begin
            tick_d = tick_inc;
            if (phase_q == PH_HUNT && tick_inc >= hdr_to_q) begin
              q_push_o = 1'b1;
              q_job_o  = '{is_frame: 1'b0, status: psfp_pkg::ST_HDR_TO};
              phase_d  = PH_IDLE;
              saw_d    = 1'b0;
            end else if (phase_q == PH_BODY && tick_inc >= body_to_q) begin
              q_push_o = 1'b1;
              q_job_o  = '{is_frame: 1'b0, status: psfp_pkg::ST_LEN};
              phase_d  = PH_IDLE;
              saw_d    = 1'b0;
            end
          end
        end
        psfp_pkg::OP_BYTE: begin
          if (phase_q == PH_HUNT) begin
            if (saw_q && in_i.byte_value == psfp_pkg::HDR_B) begin
              phase_d = PH_BODY;
              saw_d   = 1'b0;
              cnt_d   = '0;
              sum_d   = psfp_pkg::HDR_SUM;
              tick_d  = '0;
            end else begin
              saw_d = (in_i.byte_value == psfp_pkg::HDR_A);
            end
          end else if (phase_q == PH_BODY) begin
            store_wr_o.en = 1'b1;
            if (cnt_q == '0) len_d[15:8] = in_i.byte_value;
            if (cnt_q == psfp_pkg::CNT_W'(1)) len_d[7:0] = in_i.byte_value;
            if (cnt_q == CNT_CK_HI) ck_hi_d = in_i.byte_value;
            if (cnt_q < CNT_CK_HI) begin
              sum_d = sum_q + psfp_pkg::VALUE_W'(in_i.byte_value);
            end
            cnt_d = cnt_q + 1'b1;
            if (cnt_q == CNT_LAST) begin
              // last byte: low checksum byte arrives live
              q_push_o = 1'b1;
              phase_d  = PH_IDLE;
              saw_d    = 1'b0;
              if (len_q != psfp_pkg::LEN_EXPECTED) begin
                q_job_o = '{is_frame: 1'b0, status: psfp_pkg::ST_LEN};
              end else if (sum_q != {ck_hi_q, in_i.byte_value}) begin
                q_job_o = '{is_frame: 1'b0, status: psfp_pkg::ST_CKSUM};
              end else begin
                q_job_o = '{is_frame: 1'b1, status: psfp_pkg::ST_OK};
                pend_d  = 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      saw_q     <= 1'b0;
      cnt_q     <= '0;
      sum_q     <= '0;
      tick_q    <= '0;
      pend_q    <= 1'b0;
      hdr_to_q  <= psfp_pkg::HDR_TIMEOUT_RST;
      body_to_q <= psfp_pkg::BODY_TIMEOUT_RST;
    end else begin
      phase_q <= phase_d;
      saw_q   <= saw_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      tick_q  <= tick_d;
      pend_q  <= pend_d;
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == psfp_pkg::CFG_HDR_TIMEOUT) hdr_to_q <= cfg_i.data;
        if (cfg_i.index == psfp_pkg::CFG_BODY_TIMEOUT) body_to_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    len_q   <= len_d;
    ck_hi_q <= ck_hi_d;
  end

endmodule
`default_nettype wire

@@ hw/rtl/psfp_job_fifo.sv @@
// Short job queue between front and back ends.
// Uses psfp_pkg for the job type and depth.
`default_nettype none
module psfp_job_fifo (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             push_i,
  input  psfp_pkg::job_t  push_job_i,
  output logic            full_o,
  input  wire             pop_i,
  output psfp_pkg::job_t  pop_job_o,
  output logic            empty_o
);

  localparam int PTR_W = (psfp_pkg::JOB_FIFO_DEPTH > 1) ? $clog2(psfp_pkg::JOB_FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(psfp_pkg::JOB_FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(psfp_pkg::JOB_FIFO_DEPTH - 1);

  psfp_pkg::job_t    mem_q [psfp_pkg::JOB_FIFO_DEPTH];
  logic [PTR_W-1:0]  wptr_q, rptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              do_push, do_pop;

  assign full_o    = (count_q == CNT_W'(psfp_pkg::JOB_FIFO_DEPTH));
  assign empty_o   = (count_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_job_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + 1'b1;
      if (do_pop)  rptr_q <= (rptr_q == PTR_LAST) ? '0 : rptr_q + 1'b1;
      if (do_push && !do_pop) count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= push_job_i;
  end

endmodule
`default_nettype wire

@@ hw/rtl/psfp_back.sv @@
// Back end: holds the frame store, unpacks measurement words and drives the
// registered result channel. Uses psfp_pkg and psfp_if.
`default_nettype none
module psfp_back (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  psfp_pkg::store_wr_t   store_wr_i,
  input  wire                   q_empty_i,
  input  psfp_pkg::job_t        q_job_i,
  output logic                  q_pop_o,
  output psfp_pkg::back_stat_t  stat_o,
  psfp_out_if.source            out_o
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_STAT = 3'd1;
  localparam logic [2:0] B_HI   = 3'd2;
  localparam logic [2:0] B_LO   = 3'd3;
  localparam logic [2:0] B_PUT  = 3'd4;

  localparam logic [psfp_pkg::IDX_W-1:0] K_LAST = psfp_pkg::IDX_W'(psfp_pkg::NUM_WORDS - 1);
  localparam logic [psfp_pkg::POS_W-1:0] POS_CK = psfp_pkg::POS_W'(psfp_pkg::CK_POS);
  localparam logic [psfp_pkg::POS_W-1:0] POS_END = psfp_pkg::POS_W'(psfp_pkg::BODY_BYTES);

  logic [psfp_pkg::BYTE_W-1:0]   store_q [psfp_pkg::BODY_BYTES];
  logic [psfp_pkg::BYTE_W-1:0]   rd_data_q;
  logic [psfp_pkg::BYTE_W-1:0]   hi_byte_q, hi_byte_d;
  logic [2:0]                    state_q, state_d;
  logic [psfp_pkg::IDX_W-1:0]    k_q, k_d;
  psfp_pkg::status_e             stat_q, stat_d;

  logic                          ov_q, ov_d;
  logic [psfp_pkg::STATUS_W-1:0] o_status_q, o_status_d;
  logic [psfp_pkg::IDX_W-1:0]    o_idx_q, o_idx_d;
  logic [psfp_pkg::VALUE_W-1:0]  o_value_q, o_value_d;
  logic                          o_last_q, o_last_d;

  logic                          out_free;
  logic [psfp_pkg::POS_W-1:0]    pos_hi, pos_rd;
  logic [psfp_pkg::ADDR_W-1:0]   rd_addr;
  logic                          word_in_range;

  assign out_free      = !ov_q || out_o.ready;
  // high byte of word k sits at body offset 2 + 2k
  assign pos_hi        = psfp_pkg::POS_W'(2) + {k_q, 1'b0};
  // keep the low-byte address while waiting on the output register
  assign pos_rd        = (state_q == B_LO || state_q == B_PUT) ? pos_hi + 1'b1 : pos_hi;
  assign rd_addr       = (pos_rd < POS_END) ? pos_rd[psfp_pkg::ADDR_W-1:0] : '0;
  assign word_in_range = (pos_hi + 1'b1) < POS_CK;

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    stat_d     = stat_q;
    hi_byte_d  = hi_byte_q;
    q_pop_o    = 1'b0;
    stat_o     = '{frame_done: 1'b0};
    ov_d       = ov_q && !out_o.ready;
    o_status_d = o_status_q;
    o_idx_d    = o_idx_q;
    o_value_d  = o_value_q;
    o_last_d   = o_last_q;
    case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          k_d     = '0;
          stat_d  = q_job_i.status;
          state_d = q_job_i.is_frame ? B_HI : B_STAT;
        end
      end
      B_STAT: begin
        if (out_free) begin
          ov_d       = 1'b1;
          o_status_d = stat_q;
          o_idx_d    = '0;
          o_value_d  = '0;
          o_last_d   = 1'b1;
          state_d    = B_IDLE;
        end
      end
      B_HI: begin
        state_d = B_LO;
      end
      B_LO: begin
        hi_byte_d = rd_data_q;
        state_d   = B_PUT;
      end
      B_PUT: begin
        if (out_free) begin
          ov_d       = 1'b1;
          o_status_d = psfp_pkg::ST_OK;
          o_idx_d    = k_q;
          o_value_d  = word_in_range ? {hi_byte_q, rd_data_q} : '0;
          o_last_d   = (k_q == K_LAST);
          if (k_q == K_LAST) begin
            stat_o.frame_done = 1'b1;
            state_d           = B_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = B_HI;
          end
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q        <= k_d;
    stat_q     <= stat_d;
    hi_byte_q  <= hi_byte_d;
    o_status_q <= o_status_d;
    o_idx_q    <= o_idx_d;
    o_value_q  <= o_value_d;
    o_last_q   <= o_last_d;
  end

  // frame store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (store_wr_i.en) store_q[store_wr_i.addr] <= store_wr_i.data;
    rd_data_q <= store_q[rd_addr];
  end

  assign out_o.valid       = ov_q;
  assign out_o.status      = o_status_q;
  assign out_o.field_index = o_idx_q;
  assign out_o.value       = o_value_q;
  assign out_o.last        = o_last_q;

endmodule
`default_nettype wire

@@ hw/rtl/particle_sensor_frame_parser_unit.sv @@
// Top level of the particle sensor frame parser: front end, job queue, back end.
// Depends on psfp_pkg, psfp_if, psfp_front, psfp_job_fifo and psfp_back.
`default_nettype none
// A start item arms a byte-by-byte hunt for the 0x42 0x4D header; received
// bytes and millisecond ticks then arrive as items. After the header the next
// thirty bytes are stored, the length word must be 28, and the 16-bit sum of
// the first thirty frame bytes must match the trailing checksum. A good frame
// yields twelve big-endian words (field_index 0..11, last on the twelfth); a
// length error or body timeout yields status 1, a checksum error status 2,
// a header timeout status 3, each as a single result with last set.
// Input is ready whenever no good frame is being unpacked and the job queue
// is not full. Once a good frame's last byte is taken, the input holds off
// until all twelve words have been loaded into the output register; each word
// steps through B_HI, B_LO and B_PUT on the single read port of the frame
// store, and an output stall holds B_PUT. Error results pass through a
// two-entry job queue, so the front end keeps accepting while the output is
// stalled, until the queue fills. Configuration writes (index 0 header
// timeout, 1 body timeout, in ticks) are always accepted.
module particle_sensor_frame_parser_unit (
  input  wire          clk_i,
  input  wire          rst_ni,
  psfp_in_if.sink      in_i,
  psfp_cfg_if.sink     cfg_i,
  psfp_out_if.source   out_o
);

  // front end to queue
  logic                  q_push;
  psfp_pkg::job_t        q_push_job;
  logic                  q_full;
  // queue to back end
  logic                  q_pop;
  psfp_pkg::job_t        q_pop_job;
  logic                  q_empty;
  // frame store writes and frame-done handshake
  psfp_pkg::store_wr_t   store_wr;
  psfp_pkg::back_stat_t  back_stat;

  psfp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_job_o     (q_push_job),
    .store_wr_o  (store_wr),
    .back_stat_i (back_stat)
  );

  psfp_job_fifo u_job_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (q_push_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .pop_job_o  (q_pop_job),
    .empty_o    (q_empty)
  );

  psfp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .store_wr_i (store_wr),
    .q_empty_i  (q_empty),
    .q_job_i    (q_pop_job),
    .q_pop_o    (q_pop),
    .stat_o     (back_stat),
    .out_o      (out_o)
  );

endmodule
`default_nettype wire
